### rtl/crfsb_pkg.sv
`timescale 1ns / 1ps

package crfsb_pkg;

    // Command codes carried on the input channel
    typedef enum logic [2:0] {
        CMD_PUT    = 3'd0,
        CMD_FILL   = 3'd1,
        CMD_SCROLL = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    // Signed coordinate wide enough for edge plus size arithmetic
    typedef logic signed [13:0] t_coord;

endpackage

### rtl/crfsb_store.sv
`timescale 1ns / 1ps

// Frame store: one write and one read port, registered read data,
// write-to-read forwarding when both ports hit the same entry.
module crfsb_store #(
    parameter int AW = 12,
    parameter int PW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [PW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [PW-1:0] o_rdata
);

    logic [PW-1:0] r_mem [2**AW];
    logic [PW-1:0] r_q;
    logic [PW-1:0] r_fwd;
    logic          r_hit;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q   <= r_mem[i_raddr];
        r_fwd <= i_wdata;
    end

    // Same-entry write in the read cycle wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_hit ? r_fwd : r_q;

endmodule

### rtl/clipped_rect_fill_scroll_blitter_core.sv
`timescale 1ns / 1ps

// 2D blitter over a row-major frame store of frame_width by frame_height.
// Input channel (i_in_valid / o_in_stall) takes one command per transfer:
// put pixel, fill rectangle, scroll rectangle, clear frame, read pixel.
// Output channel (o_out_valid / i_out_stall) returns one result per
// command: applied flag and read data.
// A command passes the clip and plan states; fill and clear then walk the
// clipped area or the whole frame, scroll walks the clipped (overlapping)
// area and then drains, read waits for store data. Commands are handled one
// at a time: a new one is taken once the last result is registered. The walk
// over the store writes one pixel per cycle, a scroll reading and writing in
// an overlapped pipeline with forwarding.
// Reset and every size register change that alters its value start a
// clearing pass over all MAX_WIDTH*MAX_HEIGHT entries, during which
// o_in_stall is high; configuration writes are always taken.
// A result waiting under i_out_stall sits in the output register; the next
// command is accepted meanwhile and holds at its end until the slot frees.
module clipped_rect_fill_scroll_blitter_core
    import crfsb_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int PIXEL_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic [11:0]        i_rect_width,
    input  logic [11:0]        i_rect_height,
    input  logic signed [11:0] i_shift_x,
    input  logic signed [11:0] i_shift_y,
    input  logic [31:0]        i_pixel_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_applied,
    output logic [31:0]        o_read_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE - 1);
    localparam t_coord C_ONE = t_coord'(1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_CLIP, S_PLAN, S_WALK, S_DRAIN, S_RDWAIT, S_FIN
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    logic [6:0]      r_fw, r_fh;

    logic [2:0]      r_cmd;
    t_coord          r_x, r_y, r_rw, r_rh, r_sx, r_sy;
    logic [PIXEL_BITS-1:0] r_pv;

    t_coord          r_l, r_t, r_cw, r_ch;
    logic            r_ok;

    t_coord          r_src_l, r_src_t, r_dst_l, r_dst_t, r_nw, r_nh, r_i, r_j;
    logic            r_rev_x, r_rev_y, r_copy;
    logic            r_pend_v;
    logic [AW-1:0]   r_pend_dst;

    logic            r_res_applied;
    logic [31:0]     r_res_read;
    logic            r_out_valid;
    logic            r_applied;
    logic [31:0]     r_read_value;

    t_coord          w_eff, h_eff, max_w, max_h;
    t_coord          sum_r, sum_b, clip_r, clip_b, n_l, n_t;
    t_coord          s_srcl, s_srct, s_dstl, s_dstt, s_cw, s_ch;
    t_coord          dx_c, dy_c, sx_c, sy_c;
    logic [26:0]     dst_lin, src_lin;
    logic [AW-1:0]   dst_addr, src_addr;
    logic            in_frame, last_col, last_row;
    logic            cfg_wr, w_change, h_change;

    logic            st_we;
    logic [AW-1:0]   st_waddr, st_raddr;
    logic [PIXEL_BITS-1:0] st_wdata, st_rdata;
    logic [63:0]     pv64, rd64;

    // Effective frame size, saturated and emptied when either size is zero
    always_comb begin
        max_w = t_coord'(MAX_WIDTH);
        max_h = t_coord'(MAX_HEIGHT);
        if (r_fw == 7'd0 || r_fh == 7'd0) begin
            w_eff = '0;
            h_eff = '0;
        end else begin
            w_eff = ({7'd0, r_fw} > max_w) ? max_w : t_coord'({7'd0, r_fw});
            h_eff = ({7'd0, r_fh} > max_h) ? max_h : t_coord'({7'd0, r_fh});
        end
    end

    // Clipping of the latched rectangle
    always_comb begin
        sum_r  = r_x + r_rw;
        sum_b  = r_y + r_rh;
        clip_r = (sum_r > w_eff) ? w_eff : sum_r;
        clip_b = (sum_b > h_eff) ? h_eff : sum_b;
        n_l    = (r_x < 0) ? '0 : r_x;
        n_t    = (r_y < 0) ? '0 : r_y;
    end

    // Scroll overlap from the clipped rectangle
    always_comb begin
        s_srcl = r_l;
        s_dstl = r_l;
        s_cw   = r_cw;
        s_srct = r_t;
        s_dstt = r_t;
        s_ch   = r_ch;
        if (r_sx < 0) begin
            s_srcl = r_l - r_sx;
            s_cw   = r_cw + r_sx;
        end else if (r_sx > 0) begin
            s_dstl = r_l + r_sx;
            s_cw   = r_cw - r_sx;
        end
        if (r_sy < 0) begin
            s_srct = r_t - r_sy;
            s_ch   = r_ch + r_sy;
        end else if (r_sy > 0) begin
            s_dstt = r_t + r_sy;
            s_ch   = r_ch - r_sy;
        end
    end

    // Pixel coordinates and linear addresses
    always_comb begin
        if (r_state == S_PLAN) begin
            dx_c = r_x;
            dy_c = r_y;
        end else begin
            dx_c = r_dst_l + r_i;
            dy_c = r_dst_t + r_j;
        end
        sx_c     = r_src_l + r_i;
        sy_c     = r_src_t + r_j;
        dst_lin  = 27'(dy_c[12:0]) * 27'(w_eff[12:0]) + 27'(dx_c[12:0]);
        src_lin  = 27'(sy_c[12:0]) * 27'(w_eff[12:0]) + 27'(sx_c[12:0]);
        dst_addr = dst_lin[AW-1:0];
        src_addr = src_lin[AW-1:0];
        in_frame = (r_x >= 0) && (r_y >= 0) && (r_x < w_eff) && (r_y < h_eff);
        last_col = r_rev_x ? (r_i == 0) : (r_i == r_nw - C_ONE);
        last_row = r_rev_y ? (r_j == 0) : (r_j == r_nh - C_ONE);
    end

    // Store write and read port selection
    always_comb begin
        pv64     = {32'd0, i_pixel_value};
        st_we    = 1'b0;
        st_waddr = dst_addr;
        st_wdata = r_pv;
        st_raddr = (r_state == S_PLAN) ? dst_addr : src_addr;
        unique case (r_state)
            S_CLR: begin
                st_we    = 1'b1;
                st_waddr = r_clr_addr;
                st_wdata = '0;
            end
            S_PLAN: begin
                st_we = (r_cmd == CMD_PUT) && in_frame;
            end
            S_WALK: begin
                if (r_copy) begin
                    st_we    = r_pend_v;
                    st_waddr = r_pend_dst;
                    st_wdata = st_rdata;
                end else begin
                    st_we = 1'b1;
                end
            end
            S_DRAIN: begin
                st_we    = 1'b1;
                st_waddr = r_pend_dst;
                st_wdata = st_rdata;
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    crfsb_store #(
        .AW (AW),
        .PW (PIXEL_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign rd64     = 64'(st_rdata);
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign w_change = cfg_wr && (i_cfg_index == REG_FRAME_WIDTH) && (i_cfg_data != r_fw);
    assign h_change = cfg_wr && (i_cfg_index == REG_FRAME_HEIGHT) && (i_cfg_data != r_fh);

    // Command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_fw        <= '0;
            r_fh        <= '0;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_cmd;
                        r_x     <= t_coord'(i_pos_x);
                        r_y     <= t_coord'(i_pos_y);
                        r_rw    <= t_coord'({2'd0, i_rect_width});
                        r_rh    <= t_coord'({2'd0, i_rect_height});
                        r_sx    <= t_coord'(i_shift_x);
                        r_sy    <= t_coord'(i_shift_y);
                        r_pv    <= pv64[PIXEL_BITS-1:0];
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    r_l     <= n_l;
                    r_t     <= n_t;
                    r_cw    <= clip_r - n_l;
                    r_ch    <= clip_b - n_t;
                    r_ok    <= (w_eff > 0) && (h_eff > 0) && (r_rw > 0) && (r_rh > 0);
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_res_applied <= 1'b0;
                    r_res_read    <= '0;
                    r_pend_v      <= 1'b0;
                    r_state       <= S_FIN;
                    if (r_cmd == CMD_PUT) begin
                        r_res_applied <= in_frame;
                    end else if (r_cmd == CMD_READ) begin
                        r_res_applied <= in_frame;
                        if (in_frame) begin
                            r_state <= S_RDWAIT;
                        end
                    end else if (r_cmd == CMD_FILL) begin
                        r_src_l <= r_l;
                        r_src_t <= r_t;
                        r_dst_l <= r_l;
                        r_dst_t <= r_t;
                        r_nw    <= r_cw;
                        r_nh    <= r_ch;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_rev_x <= 1'b0;
                        r_rev_y <= 1'b0;
                        r_copy  <= 1'b0;
                        if (r_ok && r_cw > 0 && r_ch > 0) begin
                            r_res_applied <= 1'b1;
                            r_state       <= S_WALK;
                        end
                    end else if (r_cmd == CMD_CLEAR) begin
                        r_src_l <= '0;
                        r_src_t <= '0;
                        r_dst_l <= '0;
                        r_dst_t <= '0;
                        r_nw    <= w_eff;
                        r_nh    <= h_eff;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_rev_x <= 1'b0;
                        r_rev_y <= 1'b0;
                        r_copy  <= 1'b0;
                        if (w_eff > 0 && h_eff > 0) begin
                            r_res_applied <= 1'b1;
                            r_state       <= S_WALK;
                        end
                    end else if (r_cmd == CMD_SCROLL) begin
                        r_src_l <= s_srcl;
                        r_src_t <= s_srct;
                        r_dst_l <= s_dstl;
                        r_dst_t <= s_dstt;
                        r_nw    <= s_cw;
                        r_nh    <= s_ch;
                        r_rev_x <= r_sx > 0;
                        r_rev_y <= r_sy > 0;
                        r_i     <= (r_sx > 0) ? s_cw - C_ONE : '0;
                        r_j     <= (r_sy > 0) ? s_ch - C_ONE : '0;
                        r_copy  <= 1'b1;
                        if (r_ok && r_cw > 0 && r_ch > 0 && s_cw > 0 && s_ch > 0) begin
                            r_res_applied <= 1'b1;
                            r_state       <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    // one pixel per cycle; copies write in the cycle after the read
                    r_pend_v   <= r_copy;
                    r_pend_dst <= dst_addr;
                    if (last_col) begin
                        r_i <= r_rev_x ? r_nw - C_ONE : '0;
                        r_j <= r_rev_y ? r_j - C_ONE : r_j + C_ONE;
                        if (last_row) begin
                            r_state <= r_copy ? S_DRAIN : S_FIN;
                        end
                    end else begin
                        r_i <= r_rev_x ? r_i - C_ONE : r_i + C_ONE;
                    end
                end
                S_DRAIN: begin
                    r_pend_v <= 1'b0;
                    r_state  <= S_FIN;
                end
                S_RDWAIT: begin
                    r_res_read <= rd64[31:0];
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_applied    <= r_res_applied;
                        r_read_value <= r_res_read;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // size change: new value and a fresh clearing pass
            if (w_change) begin
                r_fw <= i_cfg_data;
            end
            if (h_change) begin
                r_fh <= i_cfg_data;
            end
            if (w_change || h_change) begin
                r_state    <= S_CLR;
                r_clr_addr <= '0;
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_applied    = r_applied;
    assign o_read_value = r_read_value;

endmodule
